/* hdl/unwind_region_lookup_macros.svh */
// assertion macros used by the region lookup engine
// each macro expects clk and arst_n in the scope where it is used
`ifndef UNWIND_REGION_LOOKUP_MACROS_SVH
`define UNWIND_REGION_LOOKUP_MACROS_SVH

// same-cycle implication, off during reset
`define URL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define URL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hdl/url_pkg.sv */
// shared constants, codes and types of the region lookup block
// no dependencies; the top level and the engine import this package
package url_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	// fixed field widths of the ports
	localparam int ADDR_W     = 32;
	localparam int SLOT_W     = 10;
	localparam int UNITS_W    = 27;
	localparam int BYTES_W    = 30;
	localparam int REG_W      = 5;
	localparam int ENTRIES_W  = 11;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 11;
	localparam int UNIT_SHIFT = 3;

	localparam logic [REG_W-1:0] RET_REG_MILLI  = 5'd31;
	localparam logic [REG_W-1:0] RET_REG_NORMAL = 5'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENTRIES_IN_USE    = 1'b0,
		CFG_FRAME_SIZE_ENABLE = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		ACT_LOOKUP = 1'b0,
		ACT_LOAD   = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CACHE,
		ST_SEARCH,
		ST_DONE
	} state_t;

	// one table entry as stored in the memory
	typedef struct packed {
		logic [ADDR_W-1:0]  rgn_start;
		logic [ADDR_W-1:0]  rgn_end;
		logic               ret_saved;
		logic               millicode;
		logic [UNITS_W-1:0] units;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// memory access from the engine
	typedef struct packed {
		logic             wr_en;
		logic [IDX_W-1:0] wr_addr;
		entry_t           wr_data;
		logic [IDX_W-1:0] rd_addr;
	} mem_req_t;

	// one lookup result
	typedef struct packed {
		logic               hit;
		logic [SLOT_W-1:0]  slot;
		logic               fs_valid;
		logic [BYTES_W-1:0] fs_bytes;
		logic [REG_W-1:0]   ret_reg;
		logic               ret_saved;
	} result_t;

endpackage

/* hdl/unwind_region_lookup.sv */
// Code-region lookup over a sorted table of up to 1024 regions held in one
// synchronous ram (start, end, frame units, flags per entry). A load request
// writes its entry in the cycle it is accepted and clears the last-hit cache;
// the block is ready again in the next cycle. A lookup request first checks the
// cached entry: on a cache hit the result is registered in the result register
// and moves from ST_DONE to the output register; then the next request is
// taken. On a miss the binary search issues one ram probe per cycle, P up to
// ceil(log2(n+1)) probes for n entries in use, and the result is registered
// when it ends; the single ram read port sets the probe rate, and a stalled
// output adds its stall. One lookup is in flight at a time, but a new request
// is taken while the previous result waits in the output register.
// Configuration writes are always ready.
// depends on url_pkg, url_ram and url_engine

module unwind_region_lookup (
	input  logic                           clk,
	input  logic                           arst_n,
	// request channel
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           action,
	input  logic [url_pkg::ADDR_W-1:0]     lookup_address,
	input  logic [url_pkg::SLOT_W-1:0]     entry_index,
	input  logic [url_pkg::ADDR_W-1:0]     region_first,
	input  logic [url_pkg::ADDR_W-1:0]     region_last,
	input  logic [url_pkg::UNITS_W-1:0]    frame_units,
	input  logic                           is_millicode,
	input  logic                           saves_return_pointer,
	// result channel
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           hit,
	output logic [url_pkg::SLOT_W-1:0]     found_index,
	output logic                           frame_size_valid,
	output logic [url_pkg::BYTES_W-1:0]    frame_size_bytes,
	output logic [url_pkg::REG_W-1:0]      return_register,
	output logic                           return_pointer_saved,
	// configuration channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [url_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [url_pkg::CFG_DATA_W-1:0] cfg_data
);
	import url_pkg::*;

	logic [ENTRIES_W-1:0] entries_q;
	logic                 fs_en_q;
	mem_req_t             mem_req;
	entry_t               mem_rd_data;
	logic [ENTRY_W-1:0]   rd_raw;
	result_t              result;

	// configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= '0;
			fs_en_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				CFG_ENTRIES_IN_USE: begin
					entries_q <= ENTRIES_W'(cfg_data);
				end
				CFG_FRAME_SIZE_ENABLE: begin
					fs_en_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// region table
	url_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (mem_req.wr_en),
		.wr_addr (mem_req.wr_addr),
		.wr_data (mem_req.wr_data),
		.rd_addr (mem_req.rd_addr),
		.rd_data (rd_raw)
	);

	assign mem_rd_data = entry_t'(rd_raw);

	// lookup sequencer
	url_engine u_engine (
		.clk                  (clk),
		.arst_n               (arst_n),
		.in_valid             (in_valid),
		.in_ready             (in_ready),
		.action               (action),
		.lookup_address       (lookup_address),
		.entry_index          (entry_index),
		.region_first         (region_first),
		.region_last          (region_last),
		.frame_units          (frame_units),
		.is_millicode         (is_millicode),
		.saves_return_pointer (saves_return_pointer),
		.entries_in_use       (entries_q),
		.frame_size_enable    (fs_en_q),
		.mem_req              (mem_req),
		.mem_rd_data          (mem_rd_data),
		.out_valid            (out_valid),
		.out_ready            (out_ready),
		.result               (result)
	);

	// result fields
	assign hit                  = result.hit;
	assign found_index          = result.slot;
	assign frame_size_valid     = result.fs_valid;
	assign frame_size_bytes     = result.fs_bytes;
	assign return_register      = result.ret_reg;
	assign return_pointer_saved = result.ret_saved;

endmodule

/* hdl/url_ram.sv */
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module url_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                          clk,
	input  logic                                          wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
	input  logic [WIDTH-1:0]                              wr_data,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
	output logic [WIDTH-1:0]                              rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule

/* hdl/url_engine.sv */
// lookup sequencer: last-hit cache check, binary search, result and output registers
// depends on url_pkg and unwind_region_lookup_macros.svh; drives the table ram
`include "unwind_region_lookup_macros.svh"

module url_engine (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          action,
	input  logic [url_pkg::ADDR_W-1:0]    lookup_address,
	input  logic [url_pkg::SLOT_W-1:0]    entry_index,
	input  logic [url_pkg::ADDR_W-1:0]    region_first,
	input  logic [url_pkg::ADDR_W-1:0]    region_last,
	input  logic [url_pkg::UNITS_W-1:0]   frame_units,
	input  logic                          is_millicode,
	input  logic                          saves_return_pointer,
	input  logic [url_pkg::ENTRIES_W-1:0] entries_in_use,
	input  logic                          frame_size_enable,
	output url_pkg::mem_req_t             mem_req,
	input  url_pkg::entry_t               mem_rd_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output url_pkg::result_t              result
);
	import url_pkg::*;

	localparam int SUM_W = CNT_W + 1;

	state_t           state_q, state_d;
	logic [ADDR_W-1:0] addr_q;
	logic [CNT_W-1:0] lo_q, lo_d;
	logic [CNT_W-1:0] hx_q, hx_d;
	logic [CNT_W-1:0] mid_q, mid_d;
	logic             cache_valid_q;
	logic [IDX_W-1:0] cached_slot_q;
	result_t          res_q;
	result_t          out_q;
	logic             out_valid_q;

	logic             accept;
	logic             load_ok;
	logic             out_free;
	logic             contains;
	logic             below;
	logic [CNT_W-1:0] n_cnt;
	logic [SUM_W-1:0] sum_init, sum_l, sum_r;
	logic [CNT_W-1:0] mid_init, mid_l, mid_r, mid_p1;
	logic             go_l_ok, go_r_ok;
	logic             finish;
	logic             fin_hit;
	logic             fin_fill;
	logic [IDX_W-1:0] fin_slot;
	logic [IDX_W-1:0] rd_addr;
	result_t          fin_res;

	// request handshake
	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign load_ok  = accept && (action_t'(action) == ACT_LOAD)
		&& (32'(entry_index) < 32'(TABLE_DEPTH));
	assign out_free = !out_valid_q || out_ready;

	// compare the address against the entry just read
	assign contains = (addr_q >= mem_rd_data.rgn_start) && (addr_q <= mem_rd_data.rgn_end);
	assign below    = addr_q < mem_rd_data.rgn_start;

	// search bounds: lo inclusive, hx exclusive; saturate the count to the depth
	assign n_cnt    = (32'(entries_in_use) > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
		: CNT_W'(entries_in_use);
	assign sum_init = SUM_W'(n_cnt) - SUM_W'(1);
	assign mid_init = CNT_W'(sum_init >> 1);

	// both possible next probes, picked once the compare is known
	assign sum_l   = SUM_W'(lo_q) + SUM_W'(mid_q) - SUM_W'(1);
	assign mid_l   = CNT_W'(sum_l >> 1);
	assign go_l_ok = lo_q < mid_q;
	assign mid_p1  = mid_q + CNT_W'(1);
	assign sum_r   = SUM_W'(mid_q) + SUM_W'(hx_q);
	assign mid_r   = CNT_W'(sum_r >> 1);
	assign go_r_ok = mid_p1 < hx_q;

	// next state and probe address
	always_comb begin
		state_d  = state_q;
		lo_d     = lo_q;
		hx_d     = hx_q;
		mid_d    = mid_q;
		rd_addr  = mid_q[IDX_W-1:0];
		finish   = 1'b0;
		fin_hit  = 1'b0;
		fin_fill = 1'b0;
		fin_slot = '0;
		case (state_q)
			ST_IDLE: begin
				rd_addr = cached_slot_q;
				if (accept && (action_t'(action) == ACT_LOOKUP)) begin
					state_d = ST_CACHE;
				end
			end
			ST_CACHE: begin
				if (cache_valid_q && contains) begin
					finish   = 1'b1;
					fin_hit  = 1'b1;
					fin_slot = cached_slot_q;
				end else if (n_cnt == '0) begin
					finish = 1'b1;
				end else begin
					lo_d    = '0;
					hx_d    = n_cnt;
					mid_d   = mid_init;
					rd_addr = mid_init[IDX_W-1:0];
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (contains) begin
					finish   = 1'b1;
					fin_hit  = 1'b1;
					fin_fill = 1'b1;
					fin_slot = mid_q[IDX_W-1:0];
				end else if (below) begin
					if (go_l_ok) begin
						hx_d    = mid_q;
						mid_d   = mid_l;
						rd_addr = mid_l[IDX_W-1:0];
					end else begin
						finish = 1'b1;
					end
				end else begin
					if (go_r_ok) begin
						lo_d    = mid_p1;
						mid_d   = mid_r;
						rd_addr = mid_r[IDX_W-1:0];
					end else begin
						finish = 1'b1;
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		if (finish) begin
			state_d = ST_DONE;
		end
	end

	// result fields from the entry read
	always_comb begin
		fin_res           = '0;
		fin_res.hit       = fin_hit;
		fin_res.slot      = fin_hit ? SLOT_W'(fin_slot) : '0;
		fin_res.fs_valid  = fin_hit && frame_size_enable;
		fin_res.fs_bytes  = fin_res.fs_valid
			? (BYTES_W'(mem_rd_data.units) << UNIT_SHIFT) : '0;
		fin_res.ret_reg   = (fin_hit && mem_rd_data.millicode) ? RET_REG_MILLI
			: RET_REG_NORMAL;
		fin_res.ret_saved = fin_hit && mem_rd_data.ret_saved;
	end

	// memory request: loads write straight through
	always_comb begin
		mem_req                   = '0;
		mem_req.wr_en             = load_ok;
		mem_req.wr_addr           = IDX_W'(entry_index);
		mem_req.wr_data.rgn_start = region_first;
		mem_req.wr_data.rgn_end   = region_last;
		mem_req.wr_data.ret_saved = saves_return_pointer;
		mem_req.wr_data.millicode = is_millicode;
		mem_req.wr_data.units     = frame_units;
		mem_req.rd_addr           = rd_addr;
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cache_valid_q <= 1'b0;
			cached_slot_q <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load_ok) begin
				cache_valid_q <= 1'b0;
				cached_slot_q <= '0;
			end else if (fin_fill) begin
				cache_valid_q <= 1'b1;
				cached_slot_q <= fin_slot;
			end
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// search and payload registers
	always_ff @(posedge clk) begin
		lo_q  <= lo_d;
		hx_q  <= hx_d;
		mid_q <= mid_d;
		if (accept) begin
			addr_q <= lookup_address;
		end
		if (finish) begin
			res_q <= fin_res;
		end
		if (state_q == ST_DONE && out_free) begin
			out_q <= res_q;
		end
	end

	assign out_valid = out_valid_q;
	assign result    = out_q;

	`URL_ASSERT_NOW(a_bounds_open, state_q == ST_SEARCH, lo_q < hx_q, "search range empty while probing")
	`URL_ASSERT_NOW(a_mid_inside, state_q == ST_SEARCH, (mid_q >= lo_q) && (mid_q < hx_q), "probe outside search range")
	`URL_ASSERT_NEXT(a_load_clears, load_ok, !cache_valid_q, "cache survived a table load")
	`URL_ASSERT_NOW(a_miss_fields, out_valid_q && !out_q.hit, (out_q.ret_reg == RET_REG_NORMAL) && !out_q.fs_valid && !out_q.ret_saved, "miss result carries hit fields")
	`URL_ASSERT_NEXT(a_done_moves, (state_q == ST_DONE) && out_free, out_valid_q && (state_q == ST_IDLE), "finished result not moved to output")

endmodule
